// ===== design/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
  } md5_state_e;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index for round r
  function automatic logic [3:0] round_g(input logic [5:0] r);
    logic [3:0] g;
    logic [3:0] rl;
    rl = r[3:0];
    unique case (r[5:4])
      2'd0: g = rl;
      2'd1: g = 4'((rl << 2) + rl + 4'd1);
      2'd2: g = 4'((rl << 1) + rl + 4'd5);
      default: g = 4'((rl << 3) - rl);
    endcase
    return g;
  endfunction

endpackage

// ===== design/md5_message_digest_core.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest_core
// Streaming MD5: bytes in, four digest words out per message.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i/in_ready_o  | in_data_i  (md5_in_t)
//  out     | out_valid_o/out_ready_i| out_data_o (md5_out_t)
// A byte is written into the block buffer when the engine takes it; each full
// block runs through the round state and then the fold state. Closing a
// message pads one byte per cycle over at most two blocks, then emits four
// words. Reset is async active low and restores the initial chaining words.
// A four-word input queue keeps input open while the engine runs rounds or
// waits on the output.
module md5_message_digest_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5_pkg::md5_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output md5_pkg::md5_out_t out_data_o
);
  import md5_pkg::*;

  logic    q_valid, q_ready;
  md5_in_t q_data;

  md5_in_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  md5_engine u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

// ===== design/md5_in_queue.sv =====
// ----------------------------------------------------------------------------
// md5_in_queue
// Small word FIFO between input handshake and the compression engine.
// ----------------------------------------------------------------------------
module md5_in_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  md5_pkg::md5_in_t in_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output md5_pkg::md5_in_t q_data_o
);
  import md5_pkg::*;

  md5_in_t      mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;
  logic push, pop;

  // idle words (no byte, no end) are dropped here
  assign in_ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign push = in_valid_i && in_ready_o &&
                (in_data_i.byte_present || in_data_i.end_of_message);
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + QAW'(1);
      if (pop) rp_q <= rp_q + QAW'(1);
      cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule

// ===== design/md5_engine.sv =====
// ----------------------------------------------------------------------------
// md5_engine
// Block buffer, padding sequencer, one-round-per-cycle compression, output.
// ----------------------------------------------------------------------------
module md5_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  md5_pkg::md5_in_t q_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output md5_pkg::md5_out_t out_data_o
);
  import md5_pkg::*;

  md5_state_e state_q, state_d;
  logic [31:0] buf_q [16];
  logic [31:0] ha_q, hb_q, hc_q, hd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] bits_q;
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic        pad_q;       // inside padding of a closing message
  logic        after_q;     // return to PAD after a block folds
  logic [1:0]  widx_q;

  logic [7:0]  pbyte;
  logic        wr_en;
  logic [31:0] f, t, rot, wg;
  logic [4:0]  s;

  // byte fed during padding
  always_comb begin
    if (!pad_q) pbyte = PAD_BYTE;
    else if (fill_q < 6'd56 || after_q) pbyte = 8'h00;
    else pbyte = bits_q[{fill_q[2:0], 3'b000} +: 8];
  end

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    wg = buf_q[round_g(rnd_q)];
    t = a_q + f + wg + round_k(rnd_q);
    s = round_s(rnd_q);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  logic take;
  assign q_ready_o = (state_q == ST_IDLE);
  assign take = q_valid_i && q_ready_o;

  always_comb begin
    state_d = state_q;
    wr_en = 1'b0;
    unique case (state_q)
      ST_IDLE: if (take) begin
        wr_en = q_data_i.byte_present;
        if (q_data_i.byte_present && fill_q == 6'd63) state_d = ST_ROUND;
        else if (q_data_i.end_of_message) state_d = ST_PAD;
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD: state_d = after_q ? ST_PAD : (pad_q ? ST_EMIT : ST_IDLE);
      ST_PAD: begin
        wr_en = 1'b1;
        if (fill_q == 6'd63) state_d = ST_ROUND;
      end
      ST_EMIT: if (out_ready_i && widx_q == 2'd3) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic [7:0] wbyte;
  assign wbyte = (state_q == ST_PAD) ? pbyte : q_data_i.data_byte;

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= wbyte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ha_q <= IV_A; hb_q <= IV_B; hc_q <= IV_C; hd_q <= IV_D;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      bits_q <= '0; fill_q <= '0; rnd_q <= '0;
      pad_q <= 1'b0; after_q <= 1'b0; widx_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) fill_q <= fill_q + 6'd1;
      if (take && q_data_i.byte_present) bits_q <= bits_q + 64'd8;
      if (take) after_q <= q_data_i.end_of_message;
      if (state_q == ST_PAD) begin
        pad_q <= 1'b1;
        // marker past byte 55: zero fill this block, length goes in the next
        if (!pad_q) after_q <= (fill_q >= 6'd56);
      end
      if (state_d == ST_ROUND && state_q != ST_ROUND) begin
        a_q <= ha_q; b_q <= hb_q; c_q <= hc_q; d_q <= hd_q;
        rnd_q <= '0;
      end
      if (state_q == ST_ROUND) begin
        a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
        rnd_q <= rnd_q + 6'd1;
      end
      if (state_q == ST_FOLD) begin
        ha_q <= ha_q + a_q; hb_q <= hb_q + b_q;
        hc_q <= hc_q + c_q; hd_q <= hd_q + d_q;
        after_q <= 1'b0;
      end
      if (state_q == ST_EMIT && out_ready_i) begin
        widx_q <= widx_q + 2'd1;
        if (widx_q == 2'd3) begin
          ha_q <= IV_A; hb_q <= IV_B; hc_q <= IV_C; hd_q <= IV_D;
          bits_q <= '0; fill_q <= '0; pad_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = (state_q == ST_EMIT);
  always_comb begin
    unique case (widx_q)
      2'd0: out_data_o.digest_word = ha_q;
      2'd1: out_data_o.digest_word = hb_q;
      2'd2: out_data_o.digest_word = hc_q;
      default: out_data_o.digest_word = hd_q;
    endcase
    out_data_o.word_index = widx_q;
    out_data_o.last_word = (widx_q == 2'd3);
  end
endmodule
